// ----- hdl/hrrn_pkg.sv -----
// Shared types and codes for the highest-response-ratio-next ready-set selector.
// Used by hrrn_eval, hrrn_cmp and hrrn_ready_set_selector_unit; depends on nothing.
`default_nettype none

package hrrn_pkg;

    localparam int ID_W    = 8;
    localparam int WAIT_W  = 16;
    localparam int TIME_W  = 32;
    localparam int BURST_W = 16;
    localparam int OCC_W   = 5;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_SEL = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_SELECTED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [WAIT_W-1:0]  wait_v;
        logic [TIME_W-1:0]  ready;
        logic [BURST_W-1:0] burst;
    } t_entry;

    typedef struct packed {
        logic [WAIT_W-1:0]  wait_v;
        logic [BURST_W-1:0] burst;
    } t_ratio;

endpackage

`default_nettype wire

// ----- hdl/hrrn_ready_set_selector_unit.sv -----
// Highest-response-ratio-next ready-set selector, top level; uses hrrn_pkg, hrrn_eval, hrrn_cmp.
// Enqueue, empty-set and full-set: the result passes from S_FINISH into the output register,
//   and the next accept follows in S_IDLE. Select over N tasks: S_SCAN reads and compares
//   every task, then S_SHIFT moves each task after the winner one slot down to close the gap.
// One transaction at a time, paced by the single memory read port; output stalls extend S_FINISH.
// Synchronous active-low reset empties the set and drops any pending result.
`default_nettype none

module hrrn_ready_set_selector_unit
    import hrrn_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input channel.
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_cmd,
    input  wire logic [ID_W-1:0]    i_task_id,
    input  wire logic [WAIT_W-1:0]  i_wait_so_far,
    input  wire logic [TIME_W-1:0]  i_ready_time,
    input  wire logic [BURST_W-1:0] i_burst_len,
    input  wire logic [TIME_W-1:0]  i_now,
    // Output channel.
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_status,
    output logic [ID_W-1:0]         o_chosen_id,
    output logic [WAIT_W-1:0]       o_chosen_wait,
    output logic [OCC_W-1:0]        o_occupancy
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    // The ready set lives in a single-port-write, single-port-read memory.
    t_entry        mem [SLOTS];
    t_entry        r_rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    logic [IW-1:0] rd_addr;

    t_state               r_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_src;
    logic                 r_rv;
    logic [IW-1:0]        r_rd_tag;
    logic [TIME_W-1:0]    r_now;
    logic [IW-1:0]        r_best_idx;
    logic [ID_W-1:0]      r_best_id;
    t_ratio               r_best;
    logic [1:0]           r_res_status;
    logic [ID_W-1:0]      r_res_id;
    logic [WAIT_W-1:0]    r_res_wait;

    logic                 in_accept;
    logic                 out_free;
    logic [CW-1:0]        count_m1;
    logic [CW+OCC_W-1:0]  occ_ext;
    t_entry               in_entry;

    logic                 ev_valid;
    logic [IW-1:0]        ev_idx;
    logic [ID_W-1:0]      ev_id;
    t_ratio               ev_ratio;
    logic                 better;
    logic                 take;
    logic [IW-1:0]        n_best_idx;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !o_out_valid || !i_out_stall;
    assign count_m1   = r_count - CW'(1);
    assign occ_ext    = {{OCC_W{1'b0}}, r_count};

    // Field order follows the record layout: id, wait, ready time, burst.
    assign in_entry = {i_task_id, i_wait_so_far, i_ready_time, i_burst_len};

    // Scan pipeline: memory read, then wait/burst evaluation, then the ratio compare.
    hrrn_eval #(
        .IW (IW)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rv && (r_state == S_SCAN)),
        .i_idx   (r_rd_tag),
        .i_entry (r_rd_data),
        .i_now   (r_now),
        .o_valid (ev_valid),
        .o_idx   (ev_idx),
        .o_id    (ev_id),
        .o_ratio (ev_ratio)
    );

    hrrn_cmp u_cmp (
        .i_cand   (ev_ratio),
        .i_best   (r_best),
        .o_better (better)
    );

    // The first task seeds the best; a later one replaces it only when strictly better,
    // so ties stay with the earliest inserted task.
    assign take       = ev_valid && ((ev_idx == '0) || better);
    assign n_best_idx = take ? ev_idx : r_best_idx;

    // Memory ports: enqueue writes at the tail, the gap-closing sweep writes one slot down.
    always_comb begin
        rd_addr = r_src[IW-1:0];
        if (r_state == S_SHIFT) begin
            wr_en   = r_rv;
            wr_addr = r_rd_tag - IW'(1);
            wr_data = r_rd_data;
        end else begin
            wr_en   = in_accept && (i_cmd == CMD_ENQ) && (r_count != SLOTS_C);
            wr_addr = r_count[IW-1:0];
            wr_data = in_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_src       <= '0;
            r_rv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // A finished transaction is presented once the output register is free.
            if ((r_state == S_FINISH) && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_rv <= 1'b0;
                    if (in_accept) begin
                        r_res_id   <= '0;
                        r_res_wait <= '0;
                        r_src      <= '0;
                        r_now      <= i_now;
                        if (i_cmd == CMD_ENQ) begin
                            if (r_count == SLOTS_C) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_res_status <= ST_ENQUEUED;
                                r_count      <= r_count + CW'(1);
                            end
                            r_state <= S_FINISH;
                        end else if (r_count == '0) begin
                            r_res_status <= ST_EMPTY;
                            r_state      <= S_FINISH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (take) begin
                        r_best_id <= ev_id;
                        r_best    <= ev_ratio;
                    end
                    r_best_idx <= n_best_idx;
                    if (ev_valid && (ev_idx == count_m1[IW-1:0])) begin
                        // Last task compared: close the gap from the slot after the winner.
                        r_src   <= CW'(n_best_idx) + CW'(1);
                        r_rv    <= 1'b0;
                        r_state <= S_SHIFT;
                    end else if (r_src < r_count) begin
                        // Issue one read per cycle over the occupied slots.
                        r_rv     <= 1'b1;
                        r_rd_tag <= r_src[IW-1:0];
                        r_src    <= r_src + CW'(1);
                    end else begin
                        r_rv <= 1'b0;
                    end
                end
                S_SHIFT: begin
                    if (r_src < r_count) begin
                        r_rv     <= 1'b1;
                        r_rd_tag <= r_src[IW-1:0];
                        r_src    <= r_src + CW'(1);
                    end else begin
                        r_rv <= 1'b0;
                        if (!r_rv) begin
                            r_count      <= count_m1;
                            r_res_status <= ST_SELECTED;
                            r_res_id     <= r_best_id;
                            r_res_wait   <= r_best.wait_v;
                            r_state      <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    // Hold the result until the output register is free.
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if ((r_state == S_FINISH) && out_free) begin
            o_status      <= r_res_status;
            o_chosen_id   <= r_res_id;
            o_chosen_wait <= r_res_wait;
            o_occupancy   <= occ_ext[OCC_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hrrn_eval.sv -----
// Register stage that turns one stored task record into its current wait and burst.
// Depends on hrrn_pkg.
`default_nettype none

module hrrn_eval
    import hrrn_pkg::*;
#(
    parameter int IW = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [IW-1:0]     i_idx,
    input  wire t_entry            i_entry,
    input  wire logic [TIME_W-1:0] i_now,
    output logic                   o_valid,
    output logic [IW-1:0]          o_idx,
    output logic [ID_W-1:0]        o_id,
    output t_ratio                 o_ratio
);

    logic [TIME_W+1:0] sum;
    logic              neg;
    logic              over;
    t_ratio            ratio;

    // Stored wait plus the signed clock difference, then clamped to the wait range.
    always_comb begin
        sum = {2'b00, {(TIME_W-WAIT_W){1'b0}}, i_entry.wait_v}
            + {2'b00, i_now} - {2'b00, i_entry.ready};
        neg  = sum[TIME_W+1];
        over = !neg && (|sum[TIME_W:WAIT_W]);
        if (neg) begin
            ratio.wait_v = '0;
        end else if (over) begin
            ratio.wait_v = WAIT_MAX;
        end else begin
            ratio.wait_v = sum[WAIT_W-1:0];
        end
        ratio.burst = (i_entry.burst == '0) ? BURST_W'(1) : i_entry.burst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_idx   <= i_idx;
        o_id    <= i_entry.id;
        o_ratio <= ratio;
    end

endmodule

`default_nettype wire

// ----- hdl/hrrn_cmp.sv -----
// Exact cross-multiplied compare of two response ratios.
// Depends on hrrn_pkg.
`default_nettype none

module hrrn_cmp
    import hrrn_pkg::*;
(
    input  wire t_ratio i_cand,
    input  wire t_ratio i_best,
    output logic        o_better
);

    logic [WAIT_W+BURST_W-1:0] cand_prod;
    logic [WAIT_W+BURST_W-1:0] best_prod;

    // (w+b)/b ordering equals w/b ordering, so compare w_c*b_b against w_b*b_c.
    always_comb begin
        cand_prod = {{BURST_W{1'b0}}, i_cand.wait_v} * {{WAIT_W{1'b0}}, i_best.burst};
        best_prod = {{BURST_W{1'b0}}, i_best.wait_v} * {{WAIT_W{1'b0}}, i_cand.burst};
        o_better  = cand_prod > best_prod;
    end

endmodule

`default_nettype wire

// ----- bench/tb_hrrn_ready_set_selector_unit.sv -----
// Self-checking testbench for hrrn_ready_set_selector_unit: directed edge cases, then random traffic.
// Depends on hrrn_pkg and the selector RTL; it keeps its own ready-set predictor and checks each result.

module tb_hrrn_ready_set_selector_unit;
    import hrrn_pkg::*;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 2 * SLOTS + 20;

    // One expected result of the block, one per accepted transaction.
    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   id;
        logic [WAIT_W-1:0] wt;
        logic [OCC_W-1:0]  occ;
    } t_outcome;

    // Clock, reset and all block inputs start at known values.
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               i_cmd         = CMD_ENQ;
    logic [ID_W-1:0]    i_task_id     = '0;
    logic [WAIT_W-1:0]  i_wait_so_far = '0;
    logic [TIME_W-1:0]  i_ready_time  = '0;
    logic [BURST_W-1:0] i_burst_len   = '0;
    logic [TIME_W-1:0]  i_now         = '0;
    logic               i_out_stall   = 1'b0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic [ID_W-1:0]    o_chosen_id;
    logic [WAIT_W-1:0]  o_chosen_wait;
    logic [OCC_W-1:0]   o_occupancy;

    // Predicted ready set: same insertion order as the block keeps.
    logic [ID_W-1:0]    rs_id    [SLOTS];
    logic [WAIT_W-1:0]  rs_wait  [SLOTS];
    logic [TIME_W-1:0]  rs_ready [SLOTS];
    logic [BURST_W-1:0] rs_burst [SLOTS];
    int                 rs_count = 0;

    t_outcome           pending_outcomes[$];
    int                 err_count    = 0;
    int                 cycle_count  = 0;
    int                 snd_idle_pct = 0;
    int                 rcv_idle_pct = 0;

    // Random traffic state: a running system clock and whether we are
    // currently pushing the set toward full or draining it toward empty.
    logic [TIME_W-1:0]  sim_clock = '0;
    logic               filling   = 1'b1;

    hrrn_ready_set_selector_unit #(
        .SLOTS(SLOTS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_task_id     (i_task_id),
        .i_wait_so_far (i_wait_so_far),
        .i_ready_time  (i_ready_time),
        .i_burst_len   (i_burst_len),
        .i_now         (i_now),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_chosen_id   (o_chosen_id),
        .o_chosen_wait (o_chosen_wait),
        .o_occupancy   (o_occupancy)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** hrrn_ready_set_selector_unit: FAILED **");
            $finish;
        end
    end

    // The result side stalls at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    // Effective wait of a held task at time now: stored wait plus the signed
    // distance from its ready time, clamped into the 16-bit range.
    function automatic longint aged_wait(input int slot, input logic [TIME_W-1:0] now);
        longint w;
        w = longint'({48'd0, rs_wait[slot]}) + longint'({32'd0, now})
            - longint'({32'd0, rs_ready[slot]});
        if (w < 0) w = 0;
        if (w > 65535) w = 65535;
        return w;
    endfunction

    // A zero burst counts as one so that the ratio stays defined.
    function automatic longint eff_burst(input int slot);
        return (rs_burst[slot] == '0) ? 64'd1 : longint'({48'd0, rs_burst[slot]});
    endfunction

    // Applies one transaction to the predicted set and returns the result the
    // block must produce for it. Ratios are compared by cross-multiplying
    // wait and burst; only a strictly higher ratio displaces the current
    // best, so among equal ratios the earliest inserted task wins.
    function automatic t_outcome schedule_outcome(
        input logic               cmd,
        input logic [ID_W-1:0]    id,
        input logic [WAIT_W-1:0]  wt,
        input logic [TIME_W-1:0]  rdy,
        input logic [BURST_W-1:0] bl,
        input logic [TIME_W-1:0]  now
    );
        t_outcome res;
        int       best;
        longint   best_w;
        longint   best_b;
        longint   w;
        longint   b;
        res = '0;
        if (cmd == CMD_ENQ) begin
            if (rs_count >= SLOTS) begin
                res.status = ST_FULL;
            end else begin
                rs_id[rs_count]    = id;
                rs_wait[rs_count]  = wt;
                rs_ready[rs_count] = rdy;
                rs_burst[rs_count] = bl;
                rs_count++;
                res.status = ST_ENQUEUED;
            end
        end else if (rs_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            best   = 0;
            best_w = aged_wait(0, now);
            best_b = eff_burst(0);
            for (int i = 1; i < rs_count; i++) begin
                w = aged_wait(i, now);
                b = eff_burst(i);
                if (w * best_b > best_w * b) begin
                    best   = i;
                    best_w = w;
                    best_b = b;
                end
            end
            res.id = rs_id[best];
            res.wt = best_w[WAIT_W-1:0];
            // Later tasks move up one slot to keep insertion order.
            for (int i = best; i < rs_count - 1; i++) begin
                rs_id[i]    = rs_id[i + 1];
                rs_wait[i]  = rs_wait[i + 1];
                rs_ready[i] = rs_ready[i + 1];
                rs_burst[i] = rs_burst[i + 1];
            end
            rs_count--;
            res.status = ST_SELECTED;
        end
        res.occ = rs_count[OCC_W-1:0];
        return res;
    endfunction

    // Offers one transaction, after a random idle gap, and holds it until the
    // block takes it. Valid stays high on return so that a back-to-back call
    // does not drop it; anything that lets time pass afterwards lowers it.
    task automatic send_item(
        input logic               cmd,
        input logic [ID_W-1:0]    id,
        input logic [WAIT_W-1:0]  wt,
        input logic [TIME_W-1:0]  rdy,
        input logic [BURST_W-1:0] bl,
        input logic [TIME_W-1:0]  now
    );
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_task_id     <= id;
        i_wait_so_far <= wt;
        i_ready_time  <= rdy;
        i_burst_len   <= bl;
        i_now         <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_outcomes.push_back(schedule_outcome(cmd, id, wt, rdy, bl, now));
    endtask

    // Holds off the input side until every outstanding result has come out.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Every accepted result is compared against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_outcome exp_o;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $error("result with no transaction pending: status %0d id %0d",
                       o_status, o_chosen_id);
                err_count++;
            end else begin
                exp_o = pending_outcomes.pop_front();
                if (o_status !== exp_o.status) begin
                    $error("status: expected %0d, got %0d", exp_o.status, o_status);
                    err_count++;
                end
                if (o_chosen_id !== exp_o.id) begin
                    $error("chosen_id: expected %0d, got %0d", exp_o.id, o_chosen_id);
                    err_count++;
                end
                if (o_chosen_wait !== exp_o.wt) begin
                    $error("chosen_wait: expected %0d, got %0d", exp_o.wt, o_chosen_wait);
                    err_count++;
                end
                if (o_occupancy !== exp_o.occ) begin
                    $error("occupancy: expected %0d, got %0d", exp_o.occ, o_occupancy);
                    err_count++;
                end
            end
        end
    end

    // A select right after reset must report an empty set.
    task automatic test_empty_select();
        send_item(CMD_SEL, ID_W'($urandom), WAIT_W'($urandom), $urandom,
                  BURST_W'($urandom), $urandom);
    endtask

    // Fills all slots with extreme and tied records, then tries one more
    // enqueue, which the block must refuse with the set unchanged.
    task automatic test_fill_to_full();
        send_item(CMD_ENQ, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000, $urandom);
        send_item(CMD_ENQ, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, $urandom);
        // Saturates once now is far past its ready time.
        send_item(CMD_ENQ, 8'hAA, 16'hFFFF, 32'h0000_0000, 16'h0001, $urandom);
        // Ready in the far future: the wait clamps to zero for small now.
        send_item(CMD_ENQ, 8'h55, 16'h0000, 32'hFFFF_FFFF, 16'h0000, $urandom);
        // Two identical tasks: equal ratios, the first one must win.
        send_item(CMD_ENQ, 8'h01, 16'd100, 32'd1000, 16'd10, $urandom);
        send_item(CMD_ENQ, 8'h02, 16'd100, 32'd1000, 16'd10, $urandom);
        for (int k = 6; k < SLOTS; k++) begin
            send_item(CMD_ENQ, ID_W'(8'h10 + k), WAIT_W'(k * 3001),
                      32'h7FFF_FFF0 + TIME_W'(k), BURST_W'(k * 5000), $urandom);
        end
        send_item(CMD_ENQ, 8'h77, 16'h1234, 32'h0BAD_F00D, 16'h0042, $urandom);
    endtask

    // Selects at the clock extremes and in between, covering clamping at
    // zero, saturation at the top and the tie between identical tasks.
    task automatic test_select_extremes();
        send_item(CMD_SEL, ID_W'($urandom), WAIT_W'($urandom), $urandom,
                  BURST_W'($urandom), 32'h0000_0000);
        send_item(CMD_SEL, ID_W'($urandom), WAIT_W'($urandom), $urandom,
                  BURST_W'($urandom), 32'hFFFF_FFFF);
        send_item(CMD_SEL, ID_W'($urandom), WAIT_W'($urandom), $urandom,
                  BURST_W'($urandom), 32'd1000);
        send_item(CMD_SEL, ID_W'($urandom), WAIT_W'($urandom), $urandom,
                  BURST_W'($urandom), 32'h8000_0000);
        send_item(CMD_SEL, ID_W'($urandom), WAIT_W'($urandom), $urandom,
                  BURST_W'($urandom), 32'h7FFF_FFFF);
        send_item(CMD_SEL, ID_W'($urandom), WAIT_W'($urandom), $urandom,
                  BURST_W'($urandom), 32'h1234_5678);
        send_item(CMD_SEL, ID_W'($urandom), WAIT_W'($urandom), $urandom,
                  BURST_W'($urandom), 32'hFFFF_FFFF);
    endtask

    // One random transaction. The mix swings the set between full and empty
    // so both refusals keep occurring, and field values lean toward small
    // waits and bursts and ready times near the running clock so that ties are common.
    task automatic send_random_item();
        logic               cmd;
        logic [WAIT_W-1:0]  wt;
        logic [BURST_W-1:0] bl;
        logic [TIME_W-1:0]  rdy;
        logic [TIME_W-1:0]  now;
        if (rs_count >= SLOTS && $urandom_range(1) == 1) filling = 1'b0;
        if (rs_count == 0 && $urandom_range(1) == 1) filling = 1'b1;
        cmd = ($urandom_range(99) < (filling ? 25 : 75)) ? CMD_SEL : CMD_ENQ;
        sim_clock = sim_clock + TIME_W'($urandom_range(200));
        case ($urandom_range(3))
            0: wt = WAIT_W'($urandom_range(3));
            1: wt = WAIT_W'($urandom);
            2: wt = WAIT_MAX - WAIT_W'($urandom_range(3));
            default: wt = WAIT_W'($urandom_range(2000));
        endcase
        case ($urandom_range(3))
            0: bl = BURST_W'($urandom_range(3));
            1: bl = BURST_W'($urandom);
            2: bl = BURST_W'($urandom_range(20, 1));
            default: bl = '1;
        endcase
        case ($urandom_range(3))
            0: rdy = sim_clock;
            1: rdy = sim_clock - TIME_W'($urandom_range(5000));
            2: rdy = $urandom;
            default: rdy = sim_clock + TIME_W'($urandom_range(1000));
        endcase
        case ($urandom_range(7))
            0: now = $urandom;
            1: now = $urandom_range(1) ? '1 : '0;
            default: now = sim_clock;
        endcase
        send_item(cmd, ID_W'($urandom), wt, rdy, bl, now);
    endtask

    // A random phase at the given idle rates, closed by a full drain of the
    // outstanding results before the next phase starts.
    task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        sim_clock    = $urandom;
        repeat (n_items) send_random_item();
        wait_for_drain();
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            rs_id[i]    = '0;
            rs_wait[i]  = '0;
            rs_ready[i] = '0;
            rs_burst[i] = '0;
        end
        snd_idle_pct = 35;
        rcv_idle_pct = 62;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_select();
        test_fill_to_full();
        test_select_extremes();
        wait_for_drain();

        test_random_traffic(135, 35, 62);
        test_random_traffic(135, 62, 35);
        test_random_traffic(135, 0, 0);

        // Any late or extra result would show up in this window.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $error("%0d results never arrived", pending_outcomes.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("** hrrn_ready_set_selector_unit: PASSED **");
        end else begin
            $display("** hrrn_ready_set_selector_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/hrrn_pkg.sv
hdl/hrrn_eval.sv
hdl/hrrn_cmp.sv
hdl/hrrn_ready_set_selector_unit.sv
bench/tb_hrrn_ready_set_selector_unit.sv
